[design/lnbt_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lnbt_pkg
// Shared types and constants for the LRU node bucket table.
// ----------------------------------------------------------------------------
package lnbt_pkg;

    // Default table geometry
    localparam int ENTRIES_DEF = 8;
    localparam int ID_BITS_DEF = 64;

    // Fixed field widths of the stream words
    localparam int NODE_ID_W  = 64;
    localparam int ADDR_W     = 32;
    localparam int PORT_W     = 16;
    localparam int PREFIX_W   = 7;
    localparam int OCC_W      = 4;
    localparam int CAP_W      = 4;

    // Packed word widths, padded to whole bytes
    localparam int S_DATA_W = 120;
    localparam int M_DATA_W = 72;

    // Capacity register after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

    // Result of one insert, handed from the table to the output register
    typedef struct packed {
        logic                 was_present;
        logic                 evicted;
        logic [NODE_ID_W-1:0] evicted_id;
        logic [OCC_W-1:0]     occupancy;
    } t_result;

endpackage
`default_nettype wire

[design/lnbt_table.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lnbt_table
// Register-held peer table: parallel identifier compare, rank-based age
// update, victim and free-slot selection. Updates when i_en is high.
// ----------------------------------------------------------------------------
module lnbt_table #(
    parameter int ENTRIES = lnbt_pkg::ENTRIES_DEF,
    parameter int ID_BITS = lnbt_pkg::ID_BITS_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_en,
    input  wire [ID_BITS-1:0]              i_id,
    input  wire [lnbt_pkg::ADDR_W-1:0]     i_addr,
    input  wire [lnbt_pkg::PORT_W-1:0]     i_port,
    input  wire [lnbt_pkg::PREFIX_W-1:0]   i_prefix,
    input  wire [lnbt_pkg::CAP_W-1:0]      i_capacity,
    output lnbt_pkg::t_result              o_result
);

    localparam int AGE_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > lnbt_pkg::CAP_W) ? CNT_W : lnbt_pkg::CAP_W;

    // Slot payload (no reset) and control state
    logic [ID_BITS-1:0]            r_slot_id     [ENTRIES];
    logic [lnbt_pkg::ADDR_W-1:0]   r_slot_addr   [ENTRIES];
    logic [lnbt_pkg::PORT_W-1:0]   r_slot_port   [ENTRIES];
    logic [lnbt_pkg::PREFIX_W-1:0] r_slot_prefix [ENTRIES];
    logic [ENTRIES-1:0]            r_valid;
    logic [AGE_W-1:0]              r_age         [ENTRIES];
    logic [CNT_W-1:0]              r_occ;

    logic [ENTRIES-1:0] hit_vec;
    logic [ENTRIES-1:0] hit_oh;
    logic [ENTRIES-1:0] old_vec;
    logic [ENTRIES-1:0] free_oh;
    logic [ENTRIES-1:0] tgt_oh;
    logic               hit;
    logic               hit_seen;
    logic               free_seen;
    logic               full;
    logic               evict;
    logic [AGE_W-1:0]   hit_age;
    logic [AGE_W-1:0]   oldest_rank;
    logic [CMP_W-1:0]   eff_cap;
    logic [ID_BITS-1:0] ev_id;
    logic [CNT_W-1:0]   n_occ;

    // Effective capacity: zero reads as one, clipped to the table size
    always_comb begin
        priority if (i_capacity == '0) begin
            eff_cap = CMP_W'(1);
        end else if (CMP_W'(i_capacity) > CMP_W'(ENTRIES)) begin
            eff_cap = CMP_W'(ENTRIES);
        end else begin
            eff_cap = CMP_W'(i_capacity);
        end
    end

    // Compare, first hit, oldest valid slot and first free slot
    always_comb begin
        hit_seen    = 1'b0;
        free_seen   = 1'b0;
        hit_oh      = '0;
        free_oh     = '0;
        hit_age     = '0;
        oldest_rank = AGE_W'(r_occ - CNT_W'(1));
        for (int i = 0; i < ENTRIES; i++) begin
            hit_vec[i] = r_valid[i] && (r_slot_id[i] == i_id);
            old_vec[i] = r_valid[i] && (r_age[i] == oldest_rank);
            if (hit_vec[i] && !hit_seen) begin
                hit_oh[i] = 1'b1;
                hit_seen  = 1'b1;
            end
            if (!r_valid[i] && !free_seen) begin
                free_oh[i] = 1'b1;
                free_seen  = 1'b1;
            end
            hit_age = hit_age | (hit_oh[i] ? r_age[i] : '0);
        end
        hit = |hit_vec;
    end

    // Decision: refresh, evict oldest, or fill a free slot
    always_comb begin
        full  = CMP_W'(r_occ) >= eff_cap;
        evict = !hit && full;
        ev_id = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            ev_id = ev_id | ((evict && old_vec[i]) ? r_slot_id[i] : '0);
        end
        priority if (hit) begin
            tgt_oh = hit_oh;
        end else if (full) begin
            tgt_oh = old_vec;
        end else begin
            tgt_oh = free_oh;
        end
        n_occ = (!hit && !full) ? r_occ + CNT_W'(1) : r_occ;

        o_result.was_present = hit;
        o_result.evicted     = evict;
        o_result.evicted_id  = lnbt_pkg::NODE_ID_W'(ev_id);
        o_result.occupancy   = lnbt_pkg::OCC_W'(n_occ);
    end

    // Valid bits, ranks and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_occ   <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_age[i] <= '0;
            end
        end else if (i_en) begin
            r_occ <= n_occ;
            for (int i = 0; i < ENTRIES; i++) begin
                if (tgt_oh[i]) begin
                    r_valid[i] <= 1'b1;
                    r_age[i]   <= '0;
                end else if (r_valid[i] && (!hit || (r_age[i] < hit_age))) begin
                    r_age[i] <= r_age[i] + AGE_W'(1);
                end
            end
        end
    end

    // Record write into the target slot
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (tgt_oh[i]) begin
                    r_slot_id[i]     <= i_id;
                    r_slot_addr[i]   <= i_addr;
                    r_slot_port[i]   <= i_port;
                    r_slot_prefix[i] <= i_prefix;
                end
            end
        end
    end

endmodule
`default_nettype wire

[design/lru_node_bucket_table_top.sv]
`default_nettype none
// An accepted input word passes the input and result registers to the master side.
// Throughput: one word per cycle unless m_axis_tready stalls; lookup, age update and
// write back all sit in one stage between the input register and the result register.
// Reset (synchronous, active low) clears the valid bits, ranks and fill count and sets
// capacity to 8; slot records are not cleared, so there is no clearing pass.
// ----------------------------------------------------------------------------
// lru_node_bucket_table_top
// Least-recently-seen peer table with stream input, stream result and a
// capacity register.
// ----------------------------------------------------------------------------
module lru_node_bucket_table_top #(
    parameter int ENTRIES = lnbt_pkg::ENTRIES_DEF,
    parameter int ID_BITS = lnbt_pkg::ID_BITS_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // capacity register
    input  wire                             i_cfg_we,
    input  wire [lnbt_pkg::CAP_W-1:0]       i_cfg_wdata,
    // input words
    input  wire                             s_axis_tvalid,
    output logic                            s_axis_tready,
    // node_id[63:0], peer_addr[95:64], peer_port[111:96], prefix_len[118:112]
    input  wire [lnbt_pkg::S_DATA_W-1:0]    s_axis_tdata,
    // result words
    output logic                            m_axis_tvalid,
    input  wire                             m_axis_tready,
    // was_present[0], evicted[1], evicted_id[65:2], occupancy[69:66]
    output logic [lnbt_pkg::M_DATA_W-1:0]   m_axis_tdata
);

    localparam int ADDR_LO   = lnbt_pkg::NODE_ID_W;
    localparam int PORT_LO   = ADDR_LO + lnbt_pkg::ADDR_W;
    localparam int PREFIX_LO = PORT_LO + lnbt_pkg::PORT_W;
    localparam int RES_W     = $bits(lnbt_pkg::t_result);

    logic [lnbt_pkg::CAP_W-1:0]    r_capacity;
    logic                          r_in_valid;
    logic [ID_BITS-1:0]            r_in_id;
    logic [lnbt_pkg::ADDR_W-1:0]   r_in_addr;
    logic [lnbt_pkg::PORT_W-1:0]   r_in_port;
    logic [lnbt_pkg::PREFIX_W-1:0] r_in_prefix;
    logic                          r_out_valid;
    lnbt_pkg::t_result             r_out;
    lnbt_pkg::t_result             result;
    logic                          advance;

    // Handshake: the table stage moves when the result register can take a word
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(lnbt_pkg::M_DATA_W - RES_W){1'b0}},
                            r_out.occupancy, r_out.evicted_id,
                            r_out.evicted, r_out.was_present};

    // Capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= lnbt_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    // Input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // Input register payload; identifier narrowed to the table width
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_id     <= s_axis_tdata[ID_BITS-1:0];
            r_in_addr   <= s_axis_tdata[PORT_LO-1:ADDR_LO];
            r_in_port   <= s_axis_tdata[PREFIX_LO-1:PORT_LO];
            r_in_prefix <= s_axis_tdata[PREFIX_LO+lnbt_pkg::PREFIX_W-1:PREFIX_LO];
        end
    end

    lnbt_table #(
        .ENTRIES (ENTRIES),
        .ID_BITS (ID_BITS)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (advance),
        .i_id       (r_in_id),
        .i_addr     (r_in_addr),
        .i_port     (r_in_port),
        .i_prefix   (r_in_prefix),
        .i_capacity (r_capacity),
        .o_result   (result)
    );

    // Result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

`ifndef SYNTHESIS
    // A refresh never evicts
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.was_present && r_out.evicted))
        else $error("result reports both hit and eviction");

    // Evicted identifier is zero unless an entry was removed
    a_evict_id_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.evicted) |-> (r_out.evicted_id == '0))
        else $error("evicted identifier set without eviction");

    // A word waiting in the input register stays until the table stage takes it
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_id)))
        else $error("pending input word lost");
`endif

endmodule
`default_nettype wire
